// ----- sv/assert_macros.svh -----
// Assertion macros for the drive unit, used by the mode module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define BRAD_CHECK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check that a condition is followed by a consequence in the next cycle
`define BRAD_CHECK_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) pre |=> post) else $error(msg);

`endif

// ----- sv/brad_pkg.sv -----
// Types, constants and coefficient tables for the avoidance drive unit
package brad_pkg;

    localparam int NUM_SENS = 8;
    localparam int SENS_W   = 12;
    localparam int SPD_W    = 11;
    localparam int LIM_W    = 10;
    localparam int COEF_W   = 8;
    localparam int PROD_W   = 20;
    localparam int SUM_W    = 21;
    localparam int ABS_W    = 20;
    localparam int Q_W      = 12;
    localparam int DRV_W    = 13;
    localparam int FAC_W    = 14;
    localparam int SCL_W    = 25;
    localparam int RECIP_K  = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [COEF_W-1:0] COEF_R [NUM_SENS] = '{
        8'sd17, 8'sd29, 8'sd34, 8'sd10, 8'sd8, -8'sd60, -8'sd64, -8'sd84
    };
    localparam logic signed [COEF_W-1:0] COEF_L [NUM_SENS] = '{
        -8'sd80, -8'sd66, -8'sd62, 8'sd8, 8'sd10, 8'sd36, 8'sd28, 8'sd18
    };

    localparam logic [Q_W-1:0]    RECIP_350   = 12'd2995;
    localparam logic [ABS_W-1:0]  SENS_DIV    = 20'd350;
    localparam logic signed [DRV_W-1:0] LEFT_OFFSET  = 13'sd66;
    localparam logic signed [DRV_W-1:0] RIGHT_OFFSET = 13'sd72;
    localparam logic [FAC_W-1:0]  SCALE_DEN   = 14'd8192;
    localparam logic signed [SCL_W-1:0] SCALE_RND = 25'sd8191;
    localparam logic [SENS_W-1:0] RIGHT_NEAR  = 12'd1300;
    localparam logic [SENS_W-1:0] LEFT_NEAR   = 12'd1200;
    localparam logic signed [SPD_W-1:0] TURN_FAST = 11'sd150;
    localparam logic signed [SPD_W-1:0] TURN_MID  = 11'sd140;
    localparam logic signed [SPD_W-1:0] TURN_SLOW = 11'sd100;
    localparam logic [NUM_SENS-1:0] ENTRY_MASK = 8'b1110_0111;

    localparam logic [SENS_W-1:0] ENTRY_TH_RST  = 12'd2100;
    localparam logic [SENS_W-1:0] EXIT_TH_RST   = 12'd70;
    localparam logic [LIM_W-1:0]  DRIVE_CAP_RST = 10'd800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_TH  = 2'd0,
        CFG_EXIT_TH   = 2'd1,
        CFG_DRIVE_CAP = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic active_mid;
        logic side;
        logic near_left_front;
        logic near_right_front;
        logic avoid_out;
    } mode_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

// ----- sv/brad_lane.sv -----
// One sensor lane: weighted products for both wheels and entry compare
module brad_lane (
    input  logic                                    aclk,
    input  logic                                    en,
    input  logic [brad_pkg::SENS_W-1:0]             sensor,
    input  logic [brad_pkg::SENS_W-1:0]             entry_th,
    input  logic signed [brad_pkg::COEF_W-1:0]      coef_r,
    input  logic signed [brad_pkg::COEF_W-1:0]      coef_l,
    output logic                                    above_entry,
    output logic signed [brad_pkg::PROD_W-1:0]      prod_r_reg,
    output logic signed [brad_pkg::PROD_W-1:0]      prod_l_reg
);
    import brad_pkg::*;

    logic signed [PROD_W:0] pr_full;
    logic signed [PROD_W:0] pl_full;

    assign pr_full     = $signed({1'b0, sensor}) * coef_r;
    assign pl_full     = $signed({1'b0, sensor}) * coef_l;
    assign above_entry = sensor > entry_th;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_r_reg <= pr_full[PROD_W-1:0];
            prod_l_reg <= pl_full[PROD_W-1:0];
        end
    end

endmodule

// ----- sv/brad_mode.sv -----
// Maximum reading and avoidance mode state
module brad_mode (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic                                en,
    input  logic [brad_pkg::SENS_W-1:0]         sensor [brad_pkg::NUM_SENS],
    input  logic [brad_pkg::NUM_SENS-1:0]       above_entry,
    input  logic [brad_pkg::SENS_W-1:0]         exit_th,
    output brad_pkg::mode_t                     mode_reg,
    output logic [brad_pkg::SENS_W-1:0]         max_reg
);
    import brad_pkg::*;

    `include "assert_macros.svh"

    logic              avoid_active_reg;
    logic              avoid_active_next;
    logic              avoid_side_reg;
    logic              avoid_side_next;
    logic              active_mid;
    logic [SENS_W-1:0] m01, m23, m45, m67, m0123, m4567, max_val;
    mode_t             mode_next;

    function automatic logic [SENS_W-1:0] max2(input logic [SENS_W-1:0] a,
                                               input logic [SENS_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    assign m01     = max2(sensor[0], sensor[1]);
    assign m23     = max2(sensor[2], sensor[3]);
    assign m45     = max2(sensor[4], sensor[5]);
    assign m67     = max2(sensor[6], sensor[7]);
    assign m0123   = max2(m01, m23);
    assign m4567   = max2(m45, m67);
    assign max_val = max2(m0123, m4567);

    always_comb begin
        active_mid      = avoid_active_reg;
        avoid_side_next = avoid_side_reg;
        if (!avoid_active_reg) begin
            if (above_entry[0] || above_entry[7]) begin
                active_mid      = 1'b1;
                avoid_side_next = !(sensor[7] < sensor[0]);
            end else if (above_entry[6] || above_entry[1]) begin
                active_mid      = 1'b1;
                avoid_side_next = !(sensor[6] < sensor[1]);
            end else if (above_entry[5] || above_entry[2]) begin
                active_mid      = 1'b1;
                avoid_side_next = !(sensor[5] < sensor[2]);
            end
        end
        avoid_active_next          = active_mid && !(max_val < exit_th);
        mode_next.active_mid       = active_mid;
        mode_next.side             = avoid_side_next;
        mode_next.near_left_front  = sensor[7] > RIGHT_NEAR;
        mode_next.near_right_front = sensor[0] > LEFT_NEAR;
        mode_next.avoid_out        = avoid_active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avoid_active_reg <= 1'b0;
            avoid_side_reg   <= 1'b0;
        end else if (accept) begin
            avoid_active_reg <= avoid_active_next;
            avoid_side_reg   <= avoid_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_reg <= mode_next;
            max_reg  <= max_val;
        end
    end

    `BRAD_CHECK_NEXT(a_state_hold, !accept, $stable(avoid_active_reg) && $stable(avoid_side_reg), "mode state moved without a request")
    `BRAD_CHECK_NEXT(a_side_kept, accept && avoid_active_reg, $stable(avoid_side_reg), "side changed while avoiding")
    `BRAD_CHECK_NEXT(a_entry_cause, accept && !avoid_active_reg && ((above_entry & ENTRY_MASK) == '0), !avoid_active_reg, "avoidance entered with no pair above threshold")

endmodule

// ----- sv/brad_merge.sv -----
// Merge of lane products: sums, division, speed scaling, clamp and result register
module brad_merge (
    input  logic                                aclk,
    input  brad_pkg::stage_en_t                 en,
    input  logic signed [brad_pkg::PROD_W-1:0]  prod_r [brad_pkg::NUM_SENS],
    input  logic signed [brad_pkg::PROD_W-1:0]  prod_l [brad_pkg::NUM_SENS],
    input  logic [brad_pkg::SENS_W-1:0]         max_in,
    input  brad_pkg::mode_t                     mode_in,
    input  logic signed [brad_pkg::SPD_W-1:0]   base_left,
    input  logic signed [brad_pkg::SPD_W-1:0]   base_right,
    input  logic [brad_pkg::LIM_W-1:0]          drive_cap,
    output logic signed [brad_pkg::SPD_W-1:0]   left_speed_reg,
    output logic signed [brad_pkg::SPD_W-1:0]   right_speed_reg,
    output logic                                avoiding_reg,
    output logic                                turning_right_reg
);
    import brad_pkg::*;

    // stage 2: sums and base speed scaling
    logic signed [SUM_W-1:0] sum_r, sum_l;
    logic signed [SUM_W-1:0] sum_r_reg, sum_l_reg;
    logic [FAC_W-1:0]        fac;
    logic signed [SCL_W-1:0] scl_l, scl_r;
    logic signed [SCL_W-1:0] scl_l_reg, scl_r_reg;
    mode_t                   mode2_reg;

    always_comb begin
        sum_r = '0;
        sum_l = '0;
        for (int i = 0; i < NUM_SENS; i++) begin
            sum_r = sum_r + SUM_W'(prod_r[i]);
            sum_l = sum_l + SUM_W'(prod_l[i]);
        end
    end

    assign fac   = SCALE_DEN - {{(FAC_W-SENS_W){1'b0}}, max_in};
    assign scl_l = base_left * $signed({1'b0, fac});
    assign scl_r = base_right * $signed({1'b0, fac});

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            sum_r_reg <= sum_r;
            sum_l_reg <= sum_l;
            scl_l_reg <= scl_l;
            scl_r_reg <= scl_r;
            mode2_reg <= mode_in;
        end
    end

    // stage 3: magnitude times reciprocal, truncated scaling, speed choice
    logic [ABS_W-1:0]            abs_r, abs_l;
    logic [ABS_W+Q_W-1:0]        rec_r, rec_l;
    logic signed [SCL_W-1:0]     adj_l, adj_r;
    logic signed [SPD_W-1:0]     spd_l, spd_r;
    logic [ABS_W-1:0]            abs_r_reg, abs_l_reg;
    logic [Q_W-1:0]              q0_r_reg, q0_l_reg;
    logic                        neg_r_reg, neg_l_reg;
    logic signed [SPD_W-1:0]     spd_l3_reg, spd_r3_reg;
    mode_t                       mode3_reg;

    assign abs_r = sum_r_reg[SUM_W-1] ? ABS_W'(-sum_r_reg) : ABS_W'(sum_r_reg);
    assign abs_l = sum_l_reg[SUM_W-1] ? ABS_W'(-sum_l_reg) : ABS_W'(sum_l_reg);
    assign rec_r = abs_r * RECIP_350;
    assign rec_l = abs_l * RECIP_350;
    assign adj_l = scl_l_reg + (scl_l_reg[SCL_W-1] ? SCALE_RND : '0);
    assign adj_r = scl_r_reg + (scl_r_reg[SCL_W-1] ? SCALE_RND : '0);

    always_comb begin
        if (!mode2_reg.active_mid) begin
            spd_l = adj_l[SCL_W-2:SCL_W-1-SPD_W];
            spd_r = adj_r[SCL_W-2:SCL_W-1-SPD_W];
        end else if (mode2_reg.side) begin
            spd_l = mode2_reg.near_left_front ? TURN_MID : TURN_SLOW;
            spd_r = TURN_FAST;
        end else begin
            spd_l = TURN_FAST;
            spd_r = mode2_reg.near_right_front ? TURN_MID : TURN_SLOW;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            abs_r_reg  <= abs_r;
            abs_l_reg  <= abs_l;
            q0_r_reg   <= rec_r[ABS_W+Q_W-1:RECIP_K];
            q0_l_reg   <= rec_l[ABS_W+Q_W-1:RECIP_K];
            neg_r_reg  <= sum_r_reg[SUM_W-1];
            neg_l_reg  <= sum_l_reg[SUM_W-1];
            spd_l3_reg <= spd_l;
            spd_r3_reg <= spd_r;
            mode3_reg  <= mode2_reg;
        end
    end

    // stage 4: quotient correction, sign and offset
    logic [ABS_W-1:0]        rem_r, rem_l;
    logic [Q_W-1:0]          q_r, q_l;
    logic signed [DRV_W-1:0] br, bl;
    logic signed [DRV_W-1:0] br_reg, bl_reg;
    logic signed [SPD_W-1:0] spd_l4_reg, spd_r4_reg;
    mode_t                   mode4_reg;

    assign rem_r = abs_r_reg - ({{(ABS_W-Q_W){1'b0}}, q0_r_reg} * SENS_DIV);
    assign rem_l = abs_l_reg - ({{(ABS_W-Q_W){1'b0}}, q0_l_reg} * SENS_DIV);
    assign q_r   = (rem_r >= SENS_DIV) ? q0_r_reg + 1'b1 : q0_r_reg;
    assign q_l   = (rem_l >= SENS_DIV) ? q0_l_reg + 1'b1 : q0_l_reg;
    assign br    = (neg_r_reg ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r})) + RIGHT_OFFSET;
    assign bl    = (neg_l_reg ? -$signed({1'b0, q_l}) : $signed({1'b0, q_l})) + LEFT_OFFSET;

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            br_reg     <= br;
            bl_reg     <= bl;
            spd_l4_reg <= spd_l3_reg;
            spd_r4_reg <= spd_r3_reg;
            mode4_reg  <= mode3_reg;
        end
    end

    // stage 5: add and clamp into the result register
    logic signed [DRV_W-1:0] tot_l, tot_r, lim, lim_neg, clp_l, clp_r;

    assign tot_l   = bl_reg + DRV_W'(spd_l4_reg);
    assign tot_r   = br_reg + DRV_W'(spd_r4_reg);
    assign lim     = $signed({{(DRV_W-LIM_W){1'b0}}, drive_cap});
    assign lim_neg = -lim;

    always_comb begin
        clp_l = tot_l;
        if (tot_l > lim) begin
            clp_l = lim;
        end else if (tot_l < lim_neg) begin
            clp_l = lim_neg;
        end
        clp_r = tot_r;
        if (tot_r > lim) begin
            clp_r = lim;
        end else if (tot_r < lim_neg) begin
            clp_r = lim_neg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            left_speed_reg    <= clp_l[SPD_W-1:0];
            right_speed_reg   <= clp_r[SPD_W-1:0];
            avoiding_reg      <= mode4_reg.avoid_out;
            turning_right_reg <= mode4_reg.side;
        end
    end

endmodule

// ----- sv/braitenberg_avoidance_drive_unit.sv -----
// Top level of the obstacle avoidance wheel drive unit
//
//  channel   direction  handshake              contents
//  s_        in         s_valid / s_ready      eight readings, two base speeds
//  m_        out        m_valid / m_ready      wheel speeds, mode flags
//  cfg_      in         cfg_valid / cfg_ready  register index and data
//
//  One request per cycle while the output is not stalled; results pass through
//  the five stage pipeline: lanes, sums, reciprocal, correction, clamp.
//  Each stage holds while the one after it is full and stalled; bubbles are absorbed.
//  Reset clears the stage valid bits and the mode state, and loads register defaults.
//  cfg_ready is always high.
module braitenberg_avoidance_drive_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [brad_pkg::SENS_W-1:0]           s_sensor_0,
    input  logic [brad_pkg::SENS_W-1:0]           s_sensor_1,
    input  logic [brad_pkg::SENS_W-1:0]           s_sensor_2,
    input  logic [brad_pkg::SENS_W-1:0]           s_sensor_3,
    input  logic [brad_pkg::SENS_W-1:0]           s_sensor_4,
    input  logic [brad_pkg::SENS_W-1:0]           s_sensor_5,
    input  logic [brad_pkg::SENS_W-1:0]           s_sensor_6,
    input  logic [brad_pkg::SENS_W-1:0]           s_sensor_7,
    input  logic signed [brad_pkg::SPD_W-1:0]     s_base_left_speed,
    input  logic signed [brad_pkg::SPD_W-1:0]     s_base_right_speed,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [brad_pkg::SPD_W-1:0]     m_left_speed,
    output logic signed [brad_pkg::SPD_W-1:0]     m_right_speed,
    output logic                                  m_avoiding,
    output logic                                  m_turning_right,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [brad_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [brad_pkg::SENS_W-1:0]           cfg_data
);
    import brad_pkg::*;

    logic [SENS_W-1:0]       entry_th_reg, exit_th_reg;
    logic [LIM_W-1:0]        drive_cap_reg;
    logic [5:1]              valid_reg;
    logic [5:1]              valid_next;
    logic [5:1]              rdy;
    stage_en_t               en;
    logic                    accept;
    logic [SENS_W-1:0]       sens [NUM_SENS];
    logic [NUM_SENS-1:0]     above_entry;
    logic signed [PROD_W-1:0] prod_r [NUM_SENS];
    logic signed [PROD_W-1:0] prod_l [NUM_SENS];
    logic signed [SPD_W-1:0] base_l_reg, base_r_reg;
    mode_t                   mode1;
    logic [SENS_W-1:0]       max1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_th_reg  <= ENTRY_TH_RST;
            exit_th_reg   <= EXIT_TH_RST;
            drive_cap_reg <= DRIVE_CAP_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ENTRY_TH:  entry_th_reg  <= cfg_data;
                CFG_EXIT_TH:   exit_th_reg   <= cfg_data;
                CFG_DRIVE_CAP: drive_cap_reg <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or its successor advances
    always_comb begin
        rdy[5] = !valid_reg[5] || m_ready;
        for (int k = 4; k >= 1; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next = valid_reg;
        valid_next[1] = rdy[1] ? s_valid : valid_reg[1];
        for (int k = 2; k <= 5; k++) begin
            if (rdy[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    assign en     = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4], s5: rdy[5]};
    assign s_ready = rdy[1];
    assign accept  = s_valid && rdy[1];
    assign m_valid = valid_reg[5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            base_l_reg <= s_base_left_speed;
            base_r_reg <= s_base_right_speed;
        end
    end

    assign sens[0] = s_sensor_0;
    assign sens[1] = s_sensor_1;
    assign sens[2] = s_sensor_2;
    assign sens[3] = s_sensor_3;
    assign sens[4] = s_sensor_4;
    assign sens[5] = s_sensor_5;
    assign sens[6] = s_sensor_6;
    assign sens[7] = s_sensor_7;

    for (genvar g = 0; g < NUM_SENS; g++) begin : g_lane
        brad_lane u_lane (
            .aclk        (aclk),
            .en          (en.s1),
            .sensor      (sens[g]),
            .entry_th    (entry_th_reg),
            .coef_r      (COEF_R[g]),
            .coef_l      (COEF_L[g]),
            .above_entry (above_entry[g]),
            .prod_r_reg  (prod_r[g]),
            .prod_l_reg  (prod_l[g])
        );
    end

    brad_mode u_mode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .en          (en.s1),
        .sensor      (sens),
        .above_entry (above_entry),
        .exit_th     (exit_th_reg),
        .mode_reg    (mode1),
        .max_reg     (max1)
    );

    brad_merge u_merge (
        .aclk              (aclk),
        .en                (en),
        .prod_r            (prod_r),
        .prod_l            (prod_l),
        .max_in            (max1),
        .mode_in           (mode1),
        .base_left         (base_l_reg),
        .base_right        (base_r_reg),
        .drive_cap         (drive_cap_reg),
        .left_speed_reg    (m_left_speed),
        .right_speed_reg   (m_right_speed),
        .avoiding_reg      (m_avoiding),
        .turning_right_reg (m_turning_right)
    );

endmodule

// ----- sim/wheel_drive_checker.sv -----
// Checker for the avoidance drive unit: predicts each wheel command and compares it
module wheel_drive_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [brad_pkg::SENS_W-1:0]        s_sensor_0,
    input  logic [brad_pkg::SENS_W-1:0]        s_sensor_1,
    input  logic [brad_pkg::SENS_W-1:0]        s_sensor_2,
    input  logic [brad_pkg::SENS_W-1:0]        s_sensor_3,
    input  logic [brad_pkg::SENS_W-1:0]        s_sensor_4,
    input  logic [brad_pkg::SENS_W-1:0]        s_sensor_5,
    input  logic [brad_pkg::SENS_W-1:0]        s_sensor_6,
    input  logic [brad_pkg::SENS_W-1:0]        s_sensor_7,
    input  logic signed [brad_pkg::SPD_W-1:0]  s_base_left_speed,
    input  logic signed [brad_pkg::SPD_W-1:0]  s_base_right_speed,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [brad_pkg::SPD_W-1:0]  m_left_speed,
    input  logic signed [brad_pkg::SPD_W-1:0]  m_right_speed,
    input  logic                               m_avoiding,
    input  logic                               m_turning_right,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [brad_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brad_pkg::SENS_W-1:0]        cfg_data,
    output int                                 mismatches,
    output int                                 outstanding
);
    import brad_pkg::*;

    localparam int SUM_DIVISOR     = 350;
    localparam int LEFT_BIAS       = 66;
    localparam int RIGHT_BIAS      = 72;
    localparam int SCALE_ONE       = 8192;
    localparam int RIGHT_CLOSE     = 1300;
    localparam int LEFT_CLOSE      = 1200;
    localparam int TURN_OUTER      = 150;
    localparam int TURN_INNER_NEAR = 140;
    localparam int TURN_INNER_FAR  = 100;
    localparam int ENTRY_DEFAULT   = 2100;
    localparam int LEAVE_DEFAULT   = 70;
    localparam int CAP_DEFAULT     = 800;

    typedef struct packed {
        logic signed [SPD_W-1:0] left_spd;
        logic signed [SPD_W-1:0] right_spd;
        logic                    avoiding;
        logic                    turning_right;
    } wheel_cmd_t;

    wheel_cmd_t pending_cmds [$];
    int weight_r [NUM_SENS] = '{17, 29, 34, 10, 8, -60, -64, -84};
    int weight_l [NUM_SENS] = '{-80, -66, -62, 8, 10, 36, 28, 18};
    int reading [NUM_SENS];
    int entry_th = ENTRY_DEFAULT;
    int leave_th = LEAVE_DEFAULT;
    int speed_cap = CAP_DEFAULT;
    bit avoid_on = 1'b0;
    bit turn_right = 1'b0;
    int errors = 0;
    int waiting = 0;

    assign mismatches = errors;
    assign outstanding = waiting;

    function automatic int clamp_drive(input int v);
        if (v > speed_cap) return speed_cap;
        if (v < -speed_cap) return -speed_cap;
        return v;
    endfunction

    function automatic wheel_cmd_t predict_drive(input int base_l, input int base_r);
        int sum_l;
        int sum_r;
        int peak;
        int spd_l;
        int spd_r;
        wheel_cmd_t cmd;
        sum_l = 0;
        sum_r = 0;
        peak = 0;
        for (int k = 0; k < NUM_SENS; k++) begin
            if (reading[k] > peak) peak = reading[k];
            sum_r += weight_r[k] * reading[k];
            sum_l += weight_l[k] * reading[k];
        end
        sum_l = sum_l / SUM_DIVISOR + LEFT_BIAS;
        sum_r = sum_r / SUM_DIVISOR + RIGHT_BIAS;

        if (!avoid_on) begin
            if (reading[0] > entry_th || reading[7] > entry_th) begin
                avoid_on = 1'b1;
                turn_right = !(reading[7] < reading[0]);
            end else if (reading[6] > entry_th || reading[1] > entry_th) begin
                avoid_on = 1'b1;
                turn_right = !(reading[6] < reading[1]);
            end else if (reading[5] > entry_th || reading[2] > entry_th) begin
                avoid_on = 1'b1;
                turn_right = !(reading[5] < reading[2]);
            end
        end

        if (!avoid_on) begin
            spd_l = base_l * (SCALE_ONE - peak) / SCALE_ONE;
            spd_r = base_r * (SCALE_ONE - peak) / SCALE_ONE;
        end else if (turn_right) begin
            spd_l = (reading[7] > RIGHT_CLOSE) ? TURN_INNER_NEAR : TURN_INNER_FAR;
            spd_r = TURN_OUTER;
        end else begin
            spd_l = TURN_OUTER;
            spd_r = (reading[0] > LEFT_CLOSE) ? TURN_INNER_NEAR : TURN_INNER_FAR;
        end

        if (avoid_on && peak < leave_th) avoid_on = 1'b0;

        cmd.left_spd = SPD_W'(clamp_drive(spd_l + sum_l));
        cmd.right_spd = SPD_W'(clamp_drive(spd_r + sum_r));
        cmd.avoiding = avoid_on;
        cmd.turning_right = turn_right;
        return cmd;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        wheel_cmd_t want;
        if (!aresetn) begin
            entry_th = ENTRY_DEFAULT;
            leave_th = LEAVE_DEFAULT;
            speed_cap = CAP_DEFAULT;
            avoid_on = 1'b0;
            turn_right = 1'b0;
            pending_cmds.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ENTRY_TH:  entry_th = int'(cfg_data);
                    CFG_EXIT_TH:   leave_th = int'(cfg_data);
                    CFG_DRIVE_CAP: speed_cap = int'(cfg_data[LIM_W-1:0]);
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_cmds.size() == 0) begin
                    $display("%0t: unexpected wheel command, expected none, got %0d %0d %0b %0b",
                             $time, m_left_speed, m_right_speed, m_avoiding, m_turning_right);
                    errors++;
                end else begin
                    want = pending_cmds.pop_front();
                    check_field("left_speed", int'(want.left_spd), int'(m_left_speed));
                    check_field("right_speed", int'(want.right_spd), int'(m_right_speed));
                    check_field("avoiding", int'(want.avoiding), int'(m_avoiding));
                    check_field("turning_right", int'(want.turning_right),
                                int'(m_turning_right));
                end
            end
            if (s_valid && s_ready) begin
                reading[0] = int'(s_sensor_0);
                reading[1] = int'(s_sensor_1);
                reading[2] = int'(s_sensor_2);
                reading[3] = int'(s_sensor_3);
                reading[4] = int'(s_sensor_4);
                reading[5] = int'(s_sensor_5);
                reading[6] = int'(s_sensor_6);
                reading[7] = int'(s_sensor_7);
                pending_cmds.push_back(predict_drive(int'(s_base_left_speed),
                                                     int'(s_base_right_speed)));
            end
        end
        waiting <= pending_cmds.size();
    end

endmodule

// ----- sim/tb_braitenberg_avoidance_drive_unit.sv -----
// Testbench top for the avoidance drive unit: request stimulus, register set-up and verdict
module tb_braitenberg_avoidance_drive_unit;
    import brad_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_STRAY = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASES       = 10;
    localparam int PHASE_TICKS  = 145;
    localparam int IDLE_PCT     = 25;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [SENS_W-1:0]       s_sensor_0 = '0;
    logic [SENS_W-1:0]       s_sensor_1 = '0;
    logic [SENS_W-1:0]       s_sensor_2 = '0;
    logic [SENS_W-1:0]       s_sensor_3 = '0;
    logic [SENS_W-1:0]       s_sensor_4 = '0;
    logic [SENS_W-1:0]       s_sensor_5 = '0;
    logic [SENS_W-1:0]       s_sensor_6 = '0;
    logic [SENS_W-1:0]       s_sensor_7 = '0;
    logic signed [SPD_W-1:0] s_base_left_speed = '0;
    logic signed [SPD_W-1:0] s_base_right_speed = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [SPD_W-1:0] m_left_speed;
    logic signed [SPD_W-1:0] m_right_speed;
    logic                    m_avoiding;
    logic                    m_turning_right;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [SENS_W-1:0]       cfg_data = '0;

    bit calm = 1'b0;
    int cycles = 0;
    int mismatches;
    int outstanding;

    braitenberg_avoidance_drive_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sensor_0         (s_sensor_0),
        .s_sensor_1         (s_sensor_1),
        .s_sensor_2         (s_sensor_2),
        .s_sensor_3         (s_sensor_3),
        .s_sensor_4         (s_sensor_4),
        .s_sensor_5         (s_sensor_5),
        .s_sensor_6         (s_sensor_6),
        .s_sensor_7         (s_sensor_7),
        .s_base_left_speed  (s_base_left_speed),
        .s_base_right_speed (s_base_right_speed),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_left_speed       (m_left_speed),
        .m_right_speed      (m_right_speed),
        .m_avoiding         (m_avoiding),
        .m_turning_right    (m_turning_right),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    wheel_drive_checker checker_i (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sensor_0         (s_sensor_0),
        .s_sensor_1         (s_sensor_1),
        .s_sensor_2         (s_sensor_2),
        .s_sensor_3         (s_sensor_3),
        .s_sensor_4         (s_sensor_4),
        .s_sensor_5         (s_sensor_5),
        .s_sensor_6         (s_sensor_6),
        .s_sensor_7         (s_sensor_7),
        .s_base_left_speed  (s_base_left_speed),
        .s_base_right_speed (s_base_right_speed),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_left_speed       (m_left_speed),
        .m_right_speed      (m_right_speed),
        .m_avoiding         (m_avoiding),
        .m_turning_right    (m_turning_right),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatches         (mismatches),
        .outstanding        (outstanding)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic drive_tick(input int r0, input int r1, input int r2, input int r3,
                              input int r4, input int r5, input int r6, input int r7,
                              input int bl, input int br);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sensor_0 <= SENS_W'(r0);
        s_sensor_1 <= SENS_W'(r1);
        s_sensor_2 <= SENS_W'(r2);
        s_sensor_3 <= SENS_W'(r3);
        s_sensor_4 <= SENS_W'(r4);
        s_sensor_5 <= SENS_W'(r5);
        s_sensor_6 <= SENS_W'(r6);
        s_sensor_7 <= SENS_W'(r7);
        s_base_left_speed <= SPD_W'(bl);
        s_base_right_speed <= SPD_W'(br);
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold requests until every wheel command has come back
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= SENS_W'(val);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_regs(input int entry, input int leave, input int cap,
                                input bit stray);
        settle();
        write_reg(CFG_ENTRY_TH, entry);
        write_reg(CFG_EXIT_TH, leave);
        write_reg(CFG_DRIVE_CAP, cap);
        if (stray) write_reg(CFG_STRAY, $urandom_range(0, 4095));
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick(input int lo_val, input int hi_val,
                                input int span_lo, input int span_hi);
        case ($urandom_range(0, 7))
            0: return lo_val;
            1: return hi_val;
            2: return $urandom_range(lo_val, hi_val);
            default: return $urandom_range(span_lo, span_hi);
        endcase
    endfunction

    task automatic random_tick();
        int r [NUM_SENS];
        int kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < NUM_SENS; k++) begin
            r[k] = (kind >= 7) ? $urandom_range(0, 4095) : $urandom_range(0, 150);
        end
        if (kind >= 4 && kind < 7) r[$urandom_range(0, NUM_SENS - 1)] = $urandom_range(0, 4095);
        drive_tick(r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7],
                   int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024);
    endtask

    initial begin
        int cap;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        drive_tick(0, 0, 0, 0, 0, 0, 0, 0, 1023, -1024);
        drive_tick(0, 0, 0, 0, 0, 0, 0, 0, -1024, 1023);
        drive_tick(2100, 2100, 2100, 2100, 2100, 2100, 2100, 2100, 500, -500);
        drive_tick(0, 0, 0, 4095, 4095, 0, 0, 0, 1023, 1023);
        drive_tick(2101, 0, 0, 0, 0, 0, 0, 100, 0, 0);
        drive_tick(69, 69, 69, 69, 69, 69, 69, 69, 0, 0);
        drive_tick(0, 0, 0, 0, 0, 0, 0, 4095, 0, 0);
        drive_tick(100, 100, 100, 100, 100, 100, 100, 1300, 0, 0);
        drive_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drive_tick(0, 3000, 0, 0, 0, 0, 0, 0, 0, 0);
        drive_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drive_tick(0, 3000, 0, 0, 0, 0, 3000, 0, 0, 0);
        drive_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drive_tick(0, 0, 4000, 0, 0, 2500, 0, 0, 0, 0);
        drive_tick(0, 0, 0, 70, 0, 0, 0, 0, 0, 0);
        drive_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drive_tick(0, 0, 100, 0, 0, 4095, 0, 0, 0, 0);
        drive_tick(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, -1024, -1024);
        drive_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        // zero speed bound through a wide write, plus a write to an unknown index
        program_regs(0, 4095, 12'h400, 1'b1);
        drive_tick(1, 0, 0, 0, 0, 0, 0, 0, 1023, -1024);
        drive_tick(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 0, 0);
        drive_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        program_regs(4095, 0, 1, 1'b0);
        drive_tick(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 1023, -1024);

        program_regs(2100, 70, 1023, 1'b0);
        drive_tick(0, 0, 4095, 4095, 4095, 4095, 4095, 4095, 1023, -1024);
        drive_tick(0, 0, 0, 0, 0, 0, 0, 0, -1024, 1023);

        for (int p = 0; p < PHASES; p++) begin
            cap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : pick(1, 1023, 100, 1023);
            program_regs(pick(0, 4095, 1200, 2800), pick(0, 4095, 20, 400), cap,
                         $urandom_range(0, 3) == 0);
            calm = (p == 3);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (p == 5 && n == PHASE_TICKS / 2) settle();
                random_tick();
            end
        end
        calm = 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
